/* rtl/core/pswnc_pkg.sv */
// ----------------------------------------------------------------------------
// pswnc_pkg
// Types and constants shared by the palette store with nearest color search.
// ----------------------------------------------------------------------------
package pswnc_pkg;

  localparam int CHAN_W     = 8;
  localparam int COLOR_W    = 3 * CHAN_W;
  localparam int INDEX_W    = 8;
  localparam int INDEX_SPAN = 256;
  localparam int DIST_W     = 10;
  localparam int S_DATA_W   = 32;
  localparam int M_DATA_W   = 40;
  localparam int M_PAD_W    = M_DATA_W - (INDEX_W + 1 + COLOR_W);

  // one above the largest possible distance
  localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(3 * 255 + 1);

  // bit positions in the result tdata
  localparam int FOUND_BIT = INDEX_W;
  localparam int COLOR_LSB = INDEX_W + 1;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_NEAREST = 2'd2,
    OP_EXACT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/palette_store_with_nearest_color.sv */
// ----------------------------------------------------------------------------
// palette_store_with_nearest_color
// RGB palette in one RAM with read, write, nearest and exact color search.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ channel, one result per command leaves on m_.
//   s_tuser carries the opcode (write, read, nearest, exact); s_tdata the
//   entry index and the color. m_tdata carries match index, found flag and
//   the color read back.
//   Only one command is in flight; s_tready is high when the block is idle.
//   A write goes straight to the result state; a read passes a read state first.
//   A search walks the min(PALETTE_SIZE, 256) entries through the single RAM
//   read port, one entry per cycle, and stops early on an exact color match;
//   the block returns to idle at the same edge that loads the result.
//   Reset clears the per-entry valid bits at once, so every entry reads as
//   black right after reset; there is no clearing pass.
//   If the receiver stalls, the result stays in the output register and the
//   block may accept and finish the next command up to its result, holding
//   it until the output register frees.
// ----------------------------------------------------------------------------
module palette_store_with_nearest_color
  import pswnc_pkg::*;
#(
  parameter int PALETTE_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // entry_index, red_in, green_in, blue_in
  input  logic [1:0]          s_tuser,  // opcode
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // match_index, found, red_out, green_out,
                                        // blue_out, zero pad
);

  localparam int SPAN  = (PALETTE_SIZE < INDEX_SPAN) ? PALETTE_SIZE : INDEX_SPAN;
  localparam int IDX_W = $clog2(SPAN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SPAN - 1);

  state_t state, state_next;

  op_t                s_op;
  logic [INDEX_W-1:0] s_idx;
  logic [COLOR_W-1:0] s_color;
  logic               s_xfer;
  logic               s_in_range;

  op_t                op;
  logic [INDEX_W-1:0] idx;
  logic [COLOR_W-1:0] color;
  logic               in_range;

  logic [SPAN-1:0]    valid_bits;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [COLOR_W-1:0] ram_rdata;

  logic [IDX_W-1:0]   scan_addr;
  logic               issue_done;
  logic               ev_valid;
  logic [IDX_W-1:0]   ev_idx;
  logic [DIST_W-1:0]  best;

  logic [INDEX_W-1:0] res_idx;
  logic               res_found;
  logic [COLOR_W-1:0] res_color;

  logic [COLOR_W-1:0] ev_entry;
  logic [COLOR_W-1:0] rd_entry;
  logic [CHAN_W-1:0]  diff_r, diff_g, diff_b;
  logic [DIST_W-1:0]  distance;
  logic               hit;
  logic               scan_end;
  logic               out_free;

  assign s_op       = op_t'(s_tuser);
  assign s_idx      = s_tdata[INDEX_W-1:0];
  assign s_color    = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
  assign s_xfer     = s_tvalid && s_tready;
  assign s_in_range = 32'(s_idx) < 32'(PALETTE_SIZE);
  assign in_range   = 32'(idx) < 32'(PALETTE_SIZE);
  assign out_free   = !m_tvalid || m_tready;

  pswnc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (SPAN)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s_idx[IDX_W-1:0]),
    .wdata (s_color),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry evaluation
  always_comb begin
    ev_entry = valid_bits[ev_idx] ? ram_rdata : '0;
    rd_entry = (in_range && valid_bits[idx[IDX_W-1:0]]) ? ram_rdata : '0;
    diff_r = (ev_entry[23:16] > color[23:16]) ? ev_entry[23:16] - color[23:16]
                                              : color[23:16] - ev_entry[23:16];
    diff_g = (ev_entry[15:8] > color[15:8]) ? ev_entry[15:8] - color[15:8]
                                            : color[15:8] - ev_entry[15:8];
    diff_b = (ev_entry[7:0] > color[7:0]) ? ev_entry[7:0] - color[7:0]
                                          : color[7:0] - ev_entry[7:0];
    distance = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);
    hit  = (op == OP_NEAREST) ? (distance == '0) : (ev_entry == color);
    scan_end = ev_valid && (hit || ev_idx == LAST_IDX);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          unique case (s_op)
            OP_WRITE:   state_next = ST_DONE;
            OP_READ:    state_next = ST_READ;
            OP_NEAREST,
            OP_EXACT:   state_next = ST_SCAN;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = s_idx[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        ram_we   = s_tvalid && (s_op == OP_WRITE) && s_in_range;
      end
      ST_SCAN: ram_raddr = scan_addr;
      ST_READ,
      ST_DONE: ram_raddr = scan_addr;
      default: ram_raddr = scan_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid_bits <= '0;
      m_tvalid   <= 1'b0;
      ev_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        valid_bits[s_idx[IDX_W-1:0]] <= 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_SCAN && !issue_done) begin
        ev_valid <= 1'b1;
      end else begin
        ev_valid <= 1'b0;
      end
    end
  end

  // command, scan and result registers
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {M_PAD_W'(0), res_color[7:0], res_color[15:8], res_color[23:16],
                  res_found, res_idx};
    end
    unique case (state)
      ST_IDLE: begin
        op         <= s_op;
        idx        <= s_idx;
        color      <= s_color;
        scan_addr  <= '0;
        issue_done <= 1'b0;
        best       <= MAX_DIST;
        res_idx    <= '0;
        res_found  <= (s_op == OP_NEAREST);
        res_color  <= '0;
      end
      ST_READ: res_color <= rd_entry;
      ST_SCAN: begin
        if (!issue_done) begin
          ev_idx <= scan_addr;
          if (scan_addr == LAST_IDX) begin
            issue_done <= 1'b1;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        if (ev_valid) begin
          if (op == OP_NEAREST) begin
            if (distance < best) begin
              best    <= distance;
              res_idx <= INDEX_W'(ev_idx);
            end
          end else if (hit) begin
            res_idx   <= INDEX_W'(ev_idx);
            res_found <= 1'b1;
          end
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule

/* rtl/core/pswnc_ram.sv */
// ----------------------------------------------------------------------------
// pswnc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pswnc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/pswnc_checker.sv */
// ----------------------------------------------------------------------------
// pswnc_checker
// Port-level checks for the palette store, bound to the top level.
// ----------------------------------------------------------------------------
module pswnc_checker
  import pswnc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one command in flight
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command taken while busy");

  // no match means index zero
  a_nomatch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[FOUND_BIT] |-> m_tdata[INDEX_W-1:0] == '0)
    else $error("index without found flag");

  // a color comes back only on a read
  a_color: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[COLOR_LSB+COLOR_W-1:COLOR_LSB] != '0
      |-> m_tdata[FOUND_BIT:0] == '0)
    else $error("color together with search result");

  // nothing left over after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind palette_store_with_nearest_color pswnc_checker u_pswnc_checker (.*);
